[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define CHK_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset
`define CHK_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[hdl/tsni_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tsni_pkg;

	// parser phases, in walk order
	typedef enum logic [4:0] {
		PH_REC_TYPE  = 5'd0,
		PH_REC_REST  = 5'd1,
		PH_HS_TYPE   = 5'd2,
		PH_HS_LEN    = 5'd3,
		PH_VER_RAND  = 5'd4,
		PH_SID_LEN   = 5'd5,
		PH_SID       = 5'd6,
		PH_CS_LEN0   = 5'd7,
		PH_CS_LEN1   = 5'd8,
		PH_CS        = 5'd9,
		PH_CM_LEN    = 5'd10,
		PH_CM        = 5'd11,
		PH_EXT_TOT0  = 5'd12,
		PH_EXT_TOT1  = 5'd13,
		PH_ET0       = 5'd14,
		PH_ET1       = 5'd15,
		PH_EL0       = 5'd16,
		PH_EL1       = 5'd17,
		PH_BODY      = 5'd18,
		PH_SNI_LIST0 = 5'd19,
		PH_SNI_LIST1 = 5'd20,
		PH_SNI_TYPE  = 5'd21,
		PH_NL0       = 5'd22,
		PH_NL1       = 5'd23,
		PH_NAME      = 5'd24,
		PH_DONE      = 5'd25,
		PH_NOT_HS    = 5'd26,
		PH_NOT_CH    = 5'd27
	} tsni_phase_t;

	typedef enum logic [2:0] {
		ST_FOUND     = 3'd0,
		ST_NOT_HS    = 3'd1,
		ST_NOT_CH    = 3'd2,
		ST_NO_SNI    = 3'd3,
		ST_TRUNCATED = 3'd4
	} tsni_status_t;

	typedef enum logic {
		KIND_NAME   = 1'b0,
		KIND_STATUS = 1'b1
	} tsni_kind_t;

	// one result item
	typedef struct packed {
		tsni_kind_t   kind;
		logic [7:0]   name_byte;
		logic         name_end;
		tsni_status_t status;
	} tsni_result_t;

	localparam logic [7:0]  REC_HANDSHAKE    = 8'd22;
	localparam logic [7:0]  MSG_CLIENT_HELLO = 8'd1;
	localparam logic [7:0]  NAME_HOST        = 8'd0;
	localparam logic [15:0] REC_REST_LEN     = 16'd4;
	localparam logic [15:0] HS_LEN_LEN       = 16'd3;
	localparam logic [15:0] VER_RAND_LEN     = 16'd34;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

endpackage

`default_nettype wire

[hdl/tsni_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tsni_parser (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  wire                   in_ready,
	input  wire [7:0]             in_data,
	input  wire                   in_last,
	output logic                  push,
	output tsni_pkg::tsni_result_t push_item
);
	import tsni_pkg::*;

	tsni_phase_t phase_q, phase_d;
	logic [15:0] field_rem_q, field_rem_d;
	logic [15:0] len_scratch_q, len_scratch_d;
	logic [15:0] ext_total_q, ext_total_d;
	logic [15:0] ext_cons_q, ext_cons_d;
	logic        ext_type_zero_q, ext_type_zero_d;
	logic [7:0]  ext_len_hi_q, ext_len_hi_d;
	logic        sni_found_q, sni_found_d;

	logic        accept;
	logic        done;
	logic        in_ext;
	logic        body_end;
	logic        emit;
	logic        name_end;
	logic [15:0] cons_inc;
	logic [15:0] fld_dec;
	logic [15:0] len16;
	logic [15:0] name_left;
	tsni_phase_t ext_end_phase;
	tsni_phase_t ph_n;
	tsni_status_t st;

	assign accept = in_valid && in_ready;
	assign done   = (phase_q == PH_DONE) || (phase_q == PH_NOT_HS) || (phase_q == PH_NOT_CH);
	assign in_ext = (phase_q >= PH_ET0) && (phase_q <= PH_NAME);

	// parse one byte
	always_comb begin
		ph_n            = phase_q;
		field_rem_d     = field_rem_q;
		len_scratch_d   = len_scratch_q;
		ext_total_d     = ext_total_q;
		ext_cons_d      = ext_cons_q;
		ext_type_zero_d = ext_type_zero_q;
		ext_len_hi_d    = ext_len_hi_q;
		sni_found_d     = sni_found_q;
		emit            = 1'b0;
		name_end        = 1'b0;
		cons_inc        = (ext_cons_q == 16'hFFFF) ? ext_cons_q : ext_cons_q + 16'd1;
		fld_dec         = field_rem_q - 16'd1;
		len16           = {len_scratch_q[7:0], in_data};
		name_left       = len_scratch_q - 16'd1;
		body_end        = (field_rem_q <= 16'd1);
		if (in_ext && !done)
			ext_cons_d = cons_inc;
		ext_end_phase = (ext_cons_d >= ext_total_q) ? PH_DONE : PH_ET0;

		if (!done) begin
			unique case (phase_q)
				PH_REC_TYPE: begin
					if (in_data != REC_HANDSHAKE) begin
						ph_n = PH_NOT_HS;
					end else begin
						field_rem_d = REC_REST_LEN;
						ph_n        = PH_REC_REST;
					end
				end
				PH_REC_REST: begin
					field_rem_d = fld_dec;
					if (fld_dec == 16'd0) ph_n = PH_HS_TYPE;
				end
				PH_HS_TYPE: begin
					if (in_data != MSG_CLIENT_HELLO) begin
						ph_n = PH_NOT_CH;
					end else begin
						field_rem_d = HS_LEN_LEN;
						ph_n        = PH_HS_LEN;
					end
				end
				PH_HS_LEN: begin
					field_rem_d = fld_dec;
					if (fld_dec == 16'd0) begin
						field_rem_d = VER_RAND_LEN;
						ph_n        = PH_VER_RAND;
					end
				end
				PH_VER_RAND: begin
					field_rem_d = fld_dec;
					if (fld_dec == 16'd0) ph_n = PH_SID_LEN;
				end
				PH_SID_LEN: begin
					field_rem_d = {8'd0, in_data};
					ph_n        = (in_data == 8'd0) ? PH_CS_LEN0 : PH_SID;
				end
				PH_SID: begin
					field_rem_d = fld_dec;
					if (fld_dec == 16'd0) ph_n = PH_CS_LEN0;
				end
				PH_CS_LEN0: begin
					len_scratch_d = {8'd0, in_data};
					ph_n          = PH_CS_LEN1;
				end
				PH_CS_LEN1: begin
					field_rem_d = len16;
					ph_n        = (len16 == 16'd0) ? PH_CM_LEN : PH_CS;
				end
				PH_CS: begin
					field_rem_d = fld_dec;
					if (fld_dec == 16'd0) ph_n = PH_CM_LEN;
				end
				PH_CM_LEN: begin
					field_rem_d = {8'd0, in_data};
					ph_n        = (in_data == 8'd0) ? PH_EXT_TOT0 : PH_CM;
				end
				PH_CM: begin
					field_rem_d = fld_dec;
					if (fld_dec == 16'd0) ph_n = PH_EXT_TOT0;
				end
				PH_EXT_TOT0: begin
					len_scratch_d = {8'd0, in_data};
					ph_n          = PH_EXT_TOT1;
				end
				PH_EXT_TOT1: begin
					ext_total_d = len16;
					ext_cons_d  = 16'd0;
					ph_n        = (len16 == 16'd0) ? PH_DONE : PH_ET0;
				end
				PH_ET0: begin
					ext_type_zero_d = (in_data == 8'd0);
					ph_n            = PH_ET1;
				end
				PH_ET1: begin
					ext_type_zero_d = ext_type_zero_q && (in_data == 8'd0);
					ph_n            = PH_EL0;
				end
				PH_EL0: begin
					ext_len_hi_d = in_data;
					ph_n         = PH_EL1;
				end
				PH_EL1: begin
					field_rem_d = {ext_len_hi_q, in_data};
					if ({ext_len_hi_q, in_data} == 16'd0)
						ph_n = ext_end_phase;
					else
						ph_n = ext_type_zero_q ? PH_SNI_LIST0 : PH_BODY;
				end
				PH_BODY, PH_SNI_LIST0, PH_SNI_LIST1, PH_SNI_TYPE,
				PH_NL0, PH_NL1, PH_NAME: begin
					unique case (phase_q)
						PH_SNI_LIST0: ph_n = PH_SNI_LIST1;
						PH_SNI_LIST1: ph_n = PH_SNI_TYPE;
						PH_SNI_TYPE:  ph_n = (in_data == NAME_HOST) ? PH_NL0 : PH_BODY;
						PH_NL0: begin
							len_scratch_d = {8'd0, in_data};
							ph_n          = PH_NL1;
						end
						PH_NL1: begin
							len_scratch_d = len16;
							if (len16 == 16'd0) begin
								sni_found_d = 1'b1;
								ph_n        = PH_BODY;
							end else begin
								ph_n = PH_NAME;
							end
						end
						PH_NAME: begin
							len_scratch_d = name_left;
							emit          = 1'b1;
							name_end      = (name_left == 16'd0) || body_end;
							if (name_end) begin
								sni_found_d = 1'b1;
								ph_n        = PH_BODY;
							end
						end
						default: ;
					endcase
					// close the extension body
					field_rem_d = body_end ? 16'd0 : fld_dec;
					if (body_end) ph_n = ext_end_phase;
				end
				default: ;
			endcase
		end

		// pick the buffer status
		priority if (ph_n == PH_NOT_HS) st = ST_NOT_HS;
		else if (ph_n == PH_NOT_CH)     st = ST_NOT_CH;
		else if (sni_found_d)           st = ST_FOUND;
		else if (ph_n == PH_DONE)       st = ST_NO_SNI;
		else                            st = ST_TRUNCATED;

		phase_d = ph_n;
		if (in_last) begin
			phase_d         = PH_REC_TYPE;
			field_rem_d     = 16'd0;
			len_scratch_d   = 16'd0;
			ext_total_d     = 16'd0;
			ext_cons_d      = 16'd0;
			ext_type_zero_d = 1'b0;
			ext_len_hi_d    = 8'd0;
			sni_found_d     = 1'b0;
		end

		push                = accept && (emit || in_last);
		push_item.kind      = in_last ? KIND_STATUS : KIND_NAME;
		push_item.name_byte = emit ? in_data : 8'd0;
		push_item.name_end  = emit && name_end;
		push_item.status    = in_last ? st : ST_FOUND;
	end

	// advance parser state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_REC_TYPE;
			field_rem_q     <= 16'd0;
			len_scratch_q   <= 16'd0;
			ext_total_q     <= 16'd0;
			ext_cons_q      <= 16'd0;
			ext_type_zero_q <= 1'b0;
			ext_len_hi_q    <= 8'd0;
			sni_found_q     <= 1'b0;
		end else if (accept) begin
			phase_q         <= phase_d;
			field_rem_q     <= field_rem_d;
			len_scratch_q   <= len_scratch_d;
			ext_total_q     <= ext_total_d;
			ext_cons_q      <= ext_cons_d;
			ext_type_zero_q <= ext_type_zero_d;
			ext_len_hi_q    <= ext_len_hi_d;
			sni_found_q     <= sni_found_d;
		end
	end

	`CHK_PROP(a_last_rewinds, accept && in_last |=> phase_q == PH_REC_TYPE && !sni_found_q, "parser not rewound after last byte")
	`CHK_PROP(a_name_in_name_phase, push && push_item.kind == KIND_NAME |-> phase_q == PH_NAME, "name byte outside name phase")
	`CHK_NEVER(a_no_byte_when_done, push && emit && done, "name byte after verdict")

endmodule

`default_nettype wire

[hdl/tsni_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tsni_queue (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  tsni_pkg::tsni_result_t push_item,
	input  wire                    pop,
	output logic                   space,
	output logic                   nonempty,
	output tsni_pkg::tsni_result_t head
);
	import tsni_pkg::*;

	tsni_result_t        slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign space    = (count_q != QCNT_W'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign head     = slot_q[rd_ptr_q];

	// store pushed items
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_item;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	`CHK_NEVER(a_push_full, push && !space, "push into full queue")
	`CHK_NEVER(a_pop_empty, pop && !nonempty, "pop from empty queue")
	`CHK_PROP(a_ptr_gap, count_q != '0 || wr_ptr_q == rd_ptr_q, "pointers apart while queue empty")

endmodule

`default_nettype wire

[hdl/tsni_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module tsni_out (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    nonempty,
	input  tsni_pkg::tsni_result_t head,
	output logic                   pop,
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output logic [15:0]            m_tdata,
	output logic                   m_tlast,
	output logic                   m_tuser
);
	import tsni_pkg::*;

	logic         valid_q;
	tsni_result_t item_q;

	// load the output register when it is free or being taken
	assign pop = nonempty && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) item_q <= head;
	end

	// format the item onto the bus
	assign m_tvalid = valid_q;
	assign m_tdata  = {5'd0, item_q.status, item_q.name_byte};
	assign m_tlast  = item_q.name_end;
	assign m_tuser  = item_q.kind;

endmodule

`default_nettype wire

[hdl/tls_client_hello_sni_extractor_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  tdata: data_byte; tlast: last_byte
// m_       out  m_tvalid/m_tready  tdata: name_byte, status; tlast: name_end;
//                                  tuser: result_kind
//
// One input byte per cycle while the result queue has space; each byte yields
// at most one item. An item is written to the result queue at the edge that
// takes its byte, then into the m_ output register once it is free or being taken.
// The four-entry result queue sets the stall: s_tready drops only while the queue
// is full.
// Reset is asynchronous; the parser then waits for a record type byte.

module tls_client_hello_sni_extractor_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] data_byte
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // [7:0] name_byte, [10:8] status, [15:11] zero
	output logic        m_tlast,
	output logic        m_tuser    // [0] result_kind
);
	import tsni_pkg::*;

	logic         push;
	logic         pop;
	logic         space;
	logic         nonempty;
	tsni_result_t push_item;
	tsni_result_t head;

	assign s_tready = space;

	tsni_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (space),
		.in_data   (s_tdata),
		.in_last   (s_tlast),
		.push      (push),
		.push_item (push_item)
	);

	tsni_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.space     (space),
		.nonempty  (nonempty),
		.head      (head)
	);

	tsni_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (nonempty),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

[tb/tb_tls_client_hello_sni_extractor_core.sv]
`timescale 1ns / 1ps

module tb_tls_client_hello_sni_extractor_core;
	import tsni_pkg::*;

	// one byte of a captured record buffer
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} rec_byte_t;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_pattern_t;

	localparam logic [7:0]  REC_APP_DATA     = 8'h17;
	localparam logic [7:0]  MSG_SERVER_HELLO = 8'h02;
	localparam logic [7:0]  NAME_OTHER       = 8'h01;
	localparam logic [15:0] SNI_EXT_TYPE     = 16'h0000;
	localparam logic [15:0] EXT_GROUPS       = 16'h000A;
	localparam logic [15:0] EXT_ALPN         = 16'h0010;
	localparam logic [15:0] EXT_TOP          = 16'hFFFF;
	localparam int RANDOM_BYTES = 90;
	localparam int HOLD_CYCLES  = 160;
	localparam int HOLD_SPACING = 1200;
	localparam int DRAIN_CYCLES = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;   // [7:0] name_byte, [10:8] status, [15:11] zero
	logic        m_tlast;   // name_end
	logic        m_tuser;   // [0] result_kind

	tls_client_hello_sni_extractor_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	rec_byte_t    pending_bytes_q[$];
	tsni_result_t sni_out_q[$];
	logic [7:0]   frame_q[$];
	logic [7:0]   ext_q[$];

	int mismatches = 0;
	int buffers = 0;
	int total_bytes = 0;
	int bytes_in = 0;
	int name_bytes_out = 0;
	int status_seen[0:4] = '{0, 0, 0, 0, 0};
	int stall_cycles = 0;
	int holds_done = 0;
	int cycle_count = 0;
	int cycle_limit = 0;

	// parser state of the predictor
	tsni_phase_t ph;
	logic [15:0] fld_left;
	logic [15:0] len_scratch;
	logic [15:0] ext_total;
	logic [15:0] ext_used;
	logic [15:0] ext_type;
	logic [15:0] ext_len;
	logic        name_seen;
	logic        parse_over;

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 50)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	function automatic void clear_parser();
		ph = PH_REC_TYPE;
		fld_left = '0;
		len_scratch = '0;
		ext_total = '0;
		ext_used = '0;
		ext_type = '0;
		ext_len = '0;
		name_seen = 1'b0;
		parse_over = 1'b0;
	endfunction

	function automatic void finish_parse(input tsni_phase_t p);
		ph = p;
		parse_over = 1'b1;
	endfunction

	// enter a counted field, or skip it right away when it is empty
	function automatic void enter_field(input logic [15:0] len, input tsni_phase_t p,
			input tsni_phase_t next_p);
		fld_left = len;
		ph = (len == 16'd0) ? next_p : p;
	endfunction

	function automatic void skip_field_byte(input tsni_phase_t next_p);
		fld_left = fld_left - 16'd1;
		if (fld_left == 16'd0)
			ph = next_p;
	endfunction

	function automatic void close_extension();
		if (ext_used >= ext_total)
			finish_parse(PH_DONE);
		else
			ph = PH_ET0;
	endfunction

	// advance the parser by one buffer byte; returns 1 when an item comes out
	function automatic bit parse_sni_byte(input logic [7:0] b, input logic last,
			output tsni_result_t res);
		tsni_phase_t cur;
		logic        emit;
		logic [7:0]  nb;
		logic        ne;
		logic        body_end;
		emit = 1'b0;
		nb = 8'd0;
		ne = 1'b0;
		res = '0;
		if (!parse_over) begin
			cur = ph;
			if (cur >= PH_ET0 && cur <= PH_NAME && ext_used != 16'hFFFF)
				ext_used = ext_used + 16'd1;
			case (cur)
				PH_REC_TYPE: begin
					if (b != REC_HANDSHAKE)
						finish_parse(PH_NOT_HS);
					else
						enter_field(REC_REST_LEN, PH_REC_REST, PH_HS_TYPE);
				end
				PH_REC_REST: skip_field_byte(PH_HS_TYPE);
				PH_HS_TYPE: begin
					if (b != MSG_CLIENT_HELLO)
						finish_parse(PH_NOT_CH);
					else
						enter_field(HS_LEN_LEN, PH_HS_LEN, PH_VER_RAND);
				end
				PH_HS_LEN: begin
					skip_field_byte(PH_VER_RAND);
					if (ph == PH_VER_RAND)
						fld_left = VER_RAND_LEN;
				end
				PH_VER_RAND: skip_field_byte(PH_SID_LEN);
				PH_SID_LEN: enter_field({8'd0, b}, PH_SID, PH_CS_LEN0);
				PH_SID: skip_field_byte(PH_CS_LEN0);
				PH_CS_LEN0: begin
					len_scratch = {8'd0, b};
					ph = PH_CS_LEN1;
				end
				PH_CS_LEN1: enter_field({len_scratch[7:0], b}, PH_CS, PH_CM_LEN);
				PH_CS: skip_field_byte(PH_CM_LEN);
				PH_CM_LEN: enter_field({8'd0, b}, PH_CM, PH_EXT_TOT0);
				PH_CM: skip_field_byte(PH_EXT_TOT0);
				PH_EXT_TOT0: begin
					len_scratch = {8'd0, b};
					ph = PH_EXT_TOT1;
				end
				PH_EXT_TOT1: begin
					ext_total = {len_scratch[7:0], b};
					ext_used = 16'd0;
					if (ext_total == 16'd0)
						finish_parse(PH_DONE);
					else
						ph = PH_ET0;
				end
				PH_ET0: begin
					ext_type = {b, 8'd0};
					ph = PH_ET1;
				end
				PH_ET1: begin
					ext_type = ext_type | {8'd0, b};
					ph = PH_EL0;
				end
				PH_EL0: begin
					ext_len = {b, 8'd0};
					ph = PH_EL1;
				end
				PH_EL1: begin
					ext_len = ext_len | {8'd0, b};
					fld_left = ext_len;
					if (ext_len == 16'd0)
						close_extension();
					else
						ph = (ext_type == SNI_EXT_TYPE) ? PH_SNI_LIST0 : PH_BODY;
				end
				default: begin
					// extension body: every byte counts against the extension length
					if (cur >= PH_BODY && cur <= PH_NAME) begin
						body_end = (fld_left <= 16'd1);
						case (cur)
							PH_SNI_LIST0: ph = PH_SNI_LIST1;
							PH_SNI_LIST1: ph = PH_SNI_TYPE;
							PH_SNI_TYPE: ph = (b == NAME_HOST) ? PH_NL0 : PH_BODY;
							PH_NL0: begin
								len_scratch = {8'd0, b};
								ph = PH_NL1;
							end
							PH_NL1: begin
								len_scratch = {len_scratch[7:0], b};
								if (len_scratch == 16'd0) begin
									name_seen = 1'b1;
									ph = PH_BODY;
								end else begin
									ph = PH_NAME;
								end
							end
							PH_NAME: begin
								len_scratch = len_scratch - 16'd1;
								emit = 1'b1;
								nb = b;
								ne = (len_scratch == 16'd0) || body_end;
								if (ne) begin
									name_seen = 1'b1;
									ph = PH_BODY;
								end
							end
							default: ;
						endcase
						fld_left = fld_left - 16'd1;
						if (body_end) begin
							fld_left = 16'd0;
							close_extension();
						end
					end
				end
			endcase
		end

		// end of buffer: one status item, then back to the record type byte
		if (last) begin
			res.kind = KIND_STATUS;
			res.name_byte = emit ? nb : 8'd0;
			res.name_end = emit & ne;
			if (ph == PH_NOT_HS)
				res.status = ST_NOT_HS;
			else if (ph == PH_NOT_CH)
				res.status = ST_NOT_CH;
			else if (name_seen)
				res.status = ST_FOUND;
			else if (ph == PH_DONE)
				res.status = ST_NO_SNI;
			else
				res.status = ST_TRUNCATED;
			clear_parser();
			return 1'b1;
		end
		res.kind = KIND_NAME;
		res.name_byte = nb;
		res.name_end = ne;
		res.status = ST_FOUND;
		return emit;
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// queue the current frame as one buffer, marking its final byte
	task automatic flush_frame();
		rec_byte_t item;
		for (int i = 0; i < frame_q.size(); i++) begin
			item.data = frame_q[i];
			item.last = (i == frame_q.size() - 1);
			pending_bytes_q.push_back(item);
		end
		buffers++;
	endtask

	task automatic send_noise(input int n, input logic [7:0] first);
		frame_q = {};
		frame_q.push_back(first);
		repeat (n - 1) frame_q.push_back(rand_byte());
		flush_frame();
	endtask

	// SNI extension; ext_len < 0 or past the body keeps the whole body, else cuts it
	task automatic add_sni_ext(input int nlen, input int nlen_field, input int ext_len,
			input logic [7:0] ntype);
		logic [7:0] body[$];
		int         keep;
		body.push_back(8'((nlen + 3) >> 8));
		body.push_back(8'(nlen + 3));
		body.push_back(ntype);
		body.push_back(8'(nlen_field >> 8));
		body.push_back(8'(nlen_field));
		repeat (nlen) body.push_back(rand_byte());
		keep = (ext_len < 0 || ext_len > body.size()) ? body.size() : ext_len;
		ext_q.push_back(SNI_EXT_TYPE[15:8]);
		ext_q.push_back(SNI_EXT_TYPE[7:0]);
		ext_q.push_back(8'(keep >> 8));
		ext_q.push_back(8'(keep));
		for (int i = 0; i < keep; i++)
			ext_q.push_back(body[i]);
	endtask

	task automatic add_other_ext(input logic [15:0] etype, input int blen);
		ext_q.push_back(etype[15:8]);
		ext_q.push_back(etype[7:0]);
		ext_q.push_back(8'(blen >> 8));
		ext_q.push_back(8'(blen));
		repeat (blen) ext_q.push_back(rand_byte());
	endtask

	// build a record around the queued extensions; ext_tot < 0 uses the real size,
	// cut > 0 keeps that many bytes, cut < 0 drops bytes from the end
	task automatic send_hello(input logic [7:0] rec_type, input logic [7:0] hs_type,
			input int sid_len, input int cs_len, input int cm_len, input int ext_tot,
			input int cut, input int pad);
		int tot;
		int keep;
		frame_q = {};
		frame_q.push_back(rec_type);
		repeat (4) frame_q.push_back(rand_byte());
		frame_q.push_back(hs_type);
		repeat (3 + 34) frame_q.push_back(rand_byte());
		frame_q.push_back(8'(sid_len));
		repeat (sid_len) frame_q.push_back(rand_byte());
		frame_q.push_back(8'(cs_len >> 8));
		frame_q.push_back(8'(cs_len));
		repeat (cs_len) frame_q.push_back(rand_byte());
		frame_q.push_back(8'(cm_len));
		repeat (cm_len) frame_q.push_back(rand_byte());
		tot = (ext_tot < 0) ? ext_q.size() : ext_tot;
		frame_q.push_back(8'(tot >> 8));
		frame_q.push_back(8'(tot));
		foreach (ext_q[i])
			frame_q.push_back(ext_q[i]);
		ext_q = {};
		if (cut > 0 && cut < frame_q.size())
			keep = cut;
		else if (cut < 0)
			keep = (frame_q.size() + cut > 0) ? frame_q.size() + cut : 1;
		else
			keep = frame_q.size();
		while (frame_q.size() > keep)
			frame_q.delete(frame_q.size() - 1);
		repeat (pad) frame_q.push_back(rand_byte());
		flush_frame();
	endtask

	// feed buffer bytes in bursts; hold a byte until it is taken
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin : byte_driver
		rec_byte_t    item;
		tsni_result_t res;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				item = pending_bytes_q.pop_front();
				if (parse_sni_byte(item.data, item.last, res))
					sni_out_q.push_back(res);
				bytes_in++;
			end
			if (s_tvalid && !s_tready) begin
				stall_cycles++;
			end else if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_bytes_q.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_bytes_q[0].data;
				s_tlast <= pending_bytes_q[0].last;
				if (burst_left <= 1) begin
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// long output hold-off, started inside a host name run so the block backs up
	int hold_left = 0;
	int hold_cool = 0;

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_cool != 0) begin
			hold_cool <= hold_cool - 1;
		end else if (arst_n && m_tvalid && m_tready && m_tuser == KIND_NAME && !m_tlast) begin
			hold_left <= HOLD_CYCLES;
			hold_cool <= HOLD_SPACING;
			holds_done++;
		end
	end

	// receiver ready pattern, switched every so often
	rx_pattern_t rx_pattern = RX_ALWAYS;
	int          rx_left = 0;

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_pattern = rx_pattern_t'($urandom_range(0, 3));
			rx_left = $urandom_range(32, 256);
		end else begin
			rx_left--;
		end
		if (!arst_n || hold_left != 0)
			m_tready <= 1'b0;
		else
			case (rx_pattern)
				RX_ALWAYS: m_tready <= 1'b1;
				RX_COIN:   m_tready <= ($urandom_range(0, 1) != 0);
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:   m_tready <= !m_tready;
			endcase
	end

	// compare each output item with the oldest pending one
	always @(posedge clk) begin : result_monitor
		tsni_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (sni_out_q.size() == 0) begin
				report_mismatch($sformatf("unexpected item kind=%0d tdata=%h tlast=%0d",
					m_tuser, m_tdata, m_tlast));
			end else begin
				want = sni_out_q.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch($sformatf("result_kind %0d, want %0d", m_tuser, want.kind));
				if (m_tdata[7:0] !== want.name_byte)
					report_mismatch($sformatf("name_byte %h, want %h", m_tdata[7:0],
						want.name_byte));
				if (m_tlast !== want.name_end)
					report_mismatch($sformatf("name_end %0d, want %0d", m_tlast, want.name_end));
				if (m_tdata[10:8] !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", m_tdata[10:8], want.status));
				if (m_tdata[15:11] !== 5'd0)
					report_mismatch($sformatf("tdata pad bits %b", m_tdata[15:11]));
				if (want.kind == KIND_STATUS)
					status_seen[want.status]++;
				else
					name_bytes_out++;
			end
		end
	end

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_limit != 0 && cycle_count >= cycle_limit) begin
			$display("Timeout after %0d cycles, %0d of %0d bytes taken, %0d items owed",
				cycle_count, bytes_in, total_bytes, sni_out_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int rand_start;
		int pick;
		int nlen;
		int kind_pick;
		int ext_tot;
		int cut;
		clear_parser();

		// short buffers: wrong record, one-byte buffers, a server hello
		send_noise(1, 8'hFF);
		send_noise(1, REC_HANDSHAKE);
		send_noise(6, REC_APP_DATA);
		send_hello(REC_HANDSHAKE, MSG_SERVER_HELLO, 0, 2, 1, -1, 0, 0);

		// plain hello with a long name among other extensions
		add_other_ext(EXT_GROUPS, 4);
		add_sni_ext(30, 30, -1, NAME_HOST);
		add_other_ext(EXT_TOP, 3);
		send_hello(REC_HANDSHAKE, MSG_CLIENT_HELLO, 4, 2, 1, -1, 0, 0);

		// empty fields and zero extensions total, trailing bytes ignored
		send_hello(REC_HANDSHAKE, MSG_CLIENT_HELLO, 0, 0, 0, 0, 0, 3);

		// name longer than its extension, and a huge name length field
		add_sni_ext(12, 20, 13, NAME_HOST);
		add_sni_ext(6, 16'hFFFF, 10, NAME_HOST);
		send_hello(REC_HANDSHAKE, MSG_CLIENT_HELLO, 1, 2, 1, -1, 0, 0);

		// extension too short for the name header, a non-host entry, an empty extension, an empty host name
		add_sni_ext(4, 4, 3, NAME_HOST);
		add_sni_ext(6, 6, -1, NAME_OTHER);
		add_sni_ext(5, 5, 0, NAME_HOST);
		add_sni_ext(0, 0, -1, NAME_HOST);
		send_hello(REC_HANDSHAKE, MSG_CLIENT_HELLO, 3, 2, 1, -1, 0, 1);

		// several SNI extensions
		add_sni_ext(5, 5, -1, NAME_HOST);
		add_other_ext(EXT_ALPN, 5);
		add_sni_ext(7, 7, -1, NAME_HOST);
		send_hello(REC_HANDSHAKE, MSG_CLIENT_HELLO, 2, 2, 1, -1, 0, 0);

		// extensions total shorter than the extensions, then longer
		add_other_ext(EXT_ALPN, 4);
		add_sni_ext(5, 5, -1, NAME_HOST);
		send_hello(REC_HANDSHAKE, MSG_CLIENT_HELLO, 0, 2, 1, 2, 0, 2);
		add_other_ext(EXT_GROUPS, 2);
		send_hello(REC_HANDSHAKE, MSG_CLIENT_HELLO, 0, 2, 1, 40, 0, 0);

		// buffer ends inside a name, on a name's last byte, and in the header
		add_sni_ext(10, 10, -1, NAME_HOST);
		send_hello(REC_HANDSHAKE, MSG_CLIENT_HELLO, 4, 2, 1, -1, -4, 0);
		add_sni_ext(9, 9, -1, NAME_HOST);
		send_hello(REC_HANDSHAKE, MSG_CLIENT_HELLO, 4, 2, 1, -1, 0, 0);
		send_hello(REC_HANDSHAKE, MSG_CLIENT_HELLO, 4, 2, 1, -1, 20, 0);

		// random buffers, mostly well-formed hellos with random extensions
		rand_start = pending_bytes_q.size();
		while (pending_bytes_q.size() - rand_start < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_noise($urandom_range(1, 12),
					($urandom_range(0, 1) != 0) ? REC_HANDSHAKE : rand_byte());
			end else if (pick < 13) begin
				send_hello(REC_HANDSHAKE, rand_byte(), $urandom_range(0, 8), 2, 1, -1, 0, 0);
			end else begin
				repeat ($urandom_range(0, 4)) begin
					kind_pick = $urandom_range(0, 9);
					nlen = $urandom_range(0, 24);
					if (kind_pick < 4)
						add_sni_ext(nlen,
							($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : nlen,
							($urandom_range(0, 9) == 0) ? $urandom_range(0, nlen + 5) : -1,
							NAME_HOST);
					else if (kind_pick == 4)
						add_sni_ext(nlen, nlen, -1, rand_byte());
					else
						add_other_ext(16'($urandom_range(1, 65535)), $urandom_range(0, 8));
				end
				ext_tot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ext_q.size() + 4) : -1;
				cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 120) : 0;
				send_hello(REC_HANDSHAKE, MSG_CLIENT_HELLO,
					($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 32),
					2 * $urandom_range(0, 8), $urandom_range(0, 3), ext_tot, cut,
					$urandom_range(0, 3));
			end
		end
		total_bytes = pending_bytes_q.size();
		cycle_limit = 100 * total_bytes + 20000;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_in != total_bytes || sni_out_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d buffers, %0d bytes: %0d host name bytes out; statuses found %0d,",
			buffers, total_bytes, name_bytes_out, status_seen[0]);
		$display("  not handshake %0d, not hello %0d, no name %0d, short %0d; %0d holds, %0d input stalls",
			status_seen[1], status_seen[2], status_seen[3], status_seen[4], holds_done,
			stall_cycles);
		if (mismatches == 0 && sni_out_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/tsni_pkg.sv
hdl/tsni_parser.sv
hdl/tsni_queue.sv
hdl/tsni_out.sv
hdl/tls_client_hello_sni_extractor_core.sv
tb/tb_tls_client_hello_sni_extractor_core.sv
